>>> rtl/core/dit_pkg.sv
// Shared constants and types for the dependency invalidation table.
// No dependencies.
package dit_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 6;
    localparam int AGE_W       = 16;
    localparam int TOKEN_W     = 32;

    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_INV_CLASS  = 3'd1;
    localparam logic [2:0] OP_INV_METHOD = 3'd2;
    localparam logic [2:0] OP_INV_SHAPE  = 3'd3;
    localparam logic [2:0] OP_ACTIVATE   = 3'd4;
    localparam logic [2:0] OP_SWEEP      = 3'd5;

    localparam logic [1:0] KIND_CLASS_LEAF   = 2'd0;
    localparam logic [1:0] KIND_METHOD_FINAL = 2'd1;
    localparam logic [1:0] KIND_SHAPE_STABLE = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TOKEN_W-1:0] subject;
        logic [TOKEN_W-1:0] method;
        logic [TOKEN_W-1:0] region;
        logic               hot;
        logic [AGE_W-1:0]   age;
    } edge_t;

endpackage

>>> rtl/core/dependency_invalidation_table_top.sv
// Top level of the dependency invalidation table: control, edge memory, result port.
// Depends on dit_pkg.
//
// A register goes straight to the summary. Every other valid operation runs repeated
// passes over the edge memory, one pass per matching edge plus a final pass. Each
// pass picks the oldest unreported match. The receiver cannot stall: each result
// is shown for one cycle with result_strobe; a sweep shows only its summary.
module dependency_invalidation_table_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  operation,
    input  logic [1:0]                  assumption_kind,
    input  logic [dit_pkg::TOKEN_W-1:0] subject_token,
    input  logic [dit_pkg::TOKEN_W-1:0] method_ident,
    input  logic [dit_pkg::TOKEN_W-1:0] region_ident,
    input  logic                        region_hot,
    output logic                        result_strobe,
    output logic                        is_summary,
    output logic                        is_lazy,
    output logic [dit_pkg::TOKEN_W-1:0] out_method,
    output logic [dit_pkg::TOKEN_W-1:0] out_region,
    output logic [dit_pkg::CNT_W-1:0]   removed_count,
    output logic [dit_pkg::CNT_W-1:0]   edge_total,
    output logic                        table_full,
    output logic                        last_result
);
    import dit_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_SUM = 3'd4;

    edge_t mem [TABLE_DEPTH];
    edge_t rd_q;

    logic [2:0]             state_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] done_reg;
    logic [AGE_W-1:0]       age_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       removed_reg;
    logic                   full_reg;
    logic [SLOT_W-1:0]      scan_reg;
    logic                   pend_reg;
    logic [SLOT_W-1:0]      pend_slot_reg;
    logic [2:0]             op_reg;
    logic [TOKEN_W-1:0]     subj_reg;
    logic [TOKEN_W-1:0]     meth_reg;
    logic [TOKEN_W-1:0]     regn_reg;
    logic                   found_reg;
    logic [AGE_W-1:0]       best_dist_reg;
    logic [SLOT_W-1:0]      best_slot_reg;
    logic [TOKEN_W-1:0]     best_meth_reg;
    logic [TOKEN_W-1:0]     best_regn_reg;
    logic                   best_hot_reg;

    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic                   cand_match;
    logic [AGE_W-1:0]       cand_dist;
    logic                   drop;
    edge_t                  wr_edge;

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        wr_edge.kind    = assumption_kind;
        wr_edge.subject = subject_token;
        wr_edge.method  = method_ident;
        wr_edge.region  = region_ident;
        wr_edge.hot     = region_hot;
        wr_edge.age     = age_reg;
    end

    always_comb
    begin
        cand_dist = age_reg - rd_q.age;
        case (op_reg)
            OP_INV_CLASS:
                cand_match = rd_q.subject == subj_reg &&
                             (rd_q.kind == KIND_CLASS_LEAF ||
                              rd_q.kind == KIND_METHOD_FINAL);
            OP_INV_METHOD:
                cand_match = rd_q.subject == subj_reg && rd_q.kind == KIND_METHOD_FINAL;
            OP_INV_SHAPE:
                cand_match = rd_q.subject == subj_reg && rd_q.kind == KIND_SHAPE_STABLE;
            OP_ACTIVATE:
                cand_match = rd_q.method == meth_reg && rd_q.region == regn_reg &&
                             !rd_q.hot;
            OP_SWEEP:
                cand_match = rd_q.method == meth_reg;
            default:
                cand_match = 1'b0;
        endcase
        cand_match = cand_match && pend_reg && valid_reg[pend_slot_reg] &&
                     !done_reg[pend_slot_reg];
        drop = (op_reg == OP_SWEEP) || (op_reg == OP_ACTIVATE) || best_hot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && operation == OP_REGISTER && free_found)
        begin
            mem[free_slot] <= wr_edge;
        end
        rd_q <= mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg   <= operation;
            subj_reg <= subject_token;
            meth_reg <= method_ident;
            regn_reg <= region_ident;
        end
        pend_slot_reg <= scan_reg;
        if (cand_match && (!found_reg || cand_dist > best_dist_reg))
        begin
            best_dist_reg <= cand_dist;
            best_slot_reg <= pend_slot_reg;
            best_meth_reg <= rd_q.method;
            best_regn_reg <= rd_q.region;
            best_hot_reg  <= rd_q.hot;
        end
        is_summary    <= 1'b0;
        is_lazy       <= 1'b0;
        out_method    <= best_meth_reg;
        out_region    <= best_regn_reg;
        removed_count <= '0;
        edge_total    <= '0;
        table_full    <= 1'b0;
        last_result   <= 1'b0;
        if (state_reg == ST_EMIT)
        begin
            is_lazy <= !drop;
        end
        if (state_reg == ST_SUM)
        begin
            is_summary    <= 1'b1;
            out_method    <= '0;
            out_region    <= '0;
            removed_count <= removed_reg;
            edge_total    <= count_reg;
            table_full    <= full_reg;
            last_result   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            done_reg      <= '0;
            age_reg       <= '0;
            count_reg     <= '0;
            removed_reg   <= '0;
            full_reg      <= 1'b0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            result_strobe <= 1'b0;
        end
        else
        begin
            result_strobe <= 1'b0;
            pend_reg      <= state_reg == ST_SCAN;
            if (cand_match)
            begin
                found_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        done_reg    <= '0;
                        removed_reg <= '0;
                        full_reg    <= 1'b0;
                        scan_reg    <= '0;
                        found_reg   <= 1'b0;
                        if (operation == OP_REGISTER)
                        begin
                            state_reg <= ST_SUM;
                            if (free_found)
                            begin
                                valid_reg[free_slot] <= 1'b1;
                                age_reg   <= age_reg + 1'b1;
                                count_reg <= count_reg + 1'b1;
                            end
                            else
                            begin
                                full_reg <= 1'b1;
                            end
                        end
                        else if (operation <= OP_SWEEP)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == SLOT_W'(TABLE_DEPTH - 1))
                    begin
                        scan_reg  <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (found_reg)
                    begin
                        found_reg               <= 1'b0;
                        done_reg[best_slot_reg] <= 1'b1;
                        result_strobe           <= op_reg != OP_SWEEP;
                        if (drop)
                        begin
                            valid_reg[best_slot_reg] <= 1'b0;
                            removed_reg <= removed_reg + 1'b1;
                            if (count_reg != '0)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    result_strobe <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = state_reg != ST_IDLE;

endmodule

>>> rtl/core/dit_checker.sv
// Port-level checks for the dependency invalidation table, bound to its top level.
// Depends on dit_pkg.
module dit_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        result_strobe,
    input logic                        is_summary,
    input logic                        last_result,
    input logic [dit_pkg::CNT_W-1:0]   removed_count,
    input logic [dit_pkg::CNT_W-1:0]   edge_total
);
    import dit_pkg::*;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted but block not busy");

    a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> last_result == is_summary)
        else $error("last result is not the summary");

    a_summary_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && is_summary |-> !busy)
        else $error("summary shown while busy");

    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !is_summary |-> removed_count == '0 && edge_total == '0)
        else $error("entry carries summary counts");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && is_summary |-> edge_total <= CNT_W'(TABLE_DEPTH))
        else $error("edge total beyond table depth");

endmodule

bind dependency_invalidation_table_top dit_checker u_dit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .is_summary    (is_summary),
    .last_result   (last_result),
    .removed_count (removed_count),
    .edge_total    (edge_total)
);
